// ===== rtl/rra_pkg.sv =====
// Shared types and constants for the ring record allocator.
// Holds the microcode word layout, datapath op codes and buffer geometry.
// No dependencies.
package rra_pkg;

  // Fixed field widths
  localparam int CFG_W = 17;
  localparam int PAY_W = 12;
  localparam int OFS_W = 16;
  localparam int SEQ_W = 32;
  localparam int EVC_W = 11;
  localparam int SZ_W  = 17;
  localparam int TOT_W = 13;

  // Buffer geometry
  localparam int MAX_BUFFER_BYTES = 65536;
  localparam int MIN_BUFFER_BYTES = 4096;
  localparam int HEADER_BYTES     = 64;
  localparam int OVERSIZE_LIMIT   = MIN_BUFFER_BYTES / 2;

  // Microprogram addresses
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_IDLE    = 3'd0;
  localparam step_t ST_PREP    = 3'd1;
  localparam step_t ST_SCAN    = 3'd2;
  localparam step_t ST_PLACE   = 3'd3;
  localparam step_t ST_SPECIAL = 3'd4;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_SCAN,
    OP_PLACE,
    OP_SPECIAL
  } op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_NEVER,
    C_ALWAYS,
    C_SPECIAL,
    C_SCAN_MORE
  } cond_t;

  // One control word of the microprogram
  typedef struct packed {
    logic  accept;
    logic  emit;
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic fire;
  } dp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic special;
    logic scan_more;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/rra_sequencer.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on rra_pkg.
module rra_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rra_pkg::dp_stat_t stat,
  output rra_pkg::dp_ctrl_t ctrl
);
  import rra_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t uw;
  logic   hold;
  logic   jump;

  // Control ROM
  always_comb begin
    unique case (step_r)
      ST_IDLE:    uw = '{accept: 1'b1, emit: 1'b0, op: OP_LOAD,
                         cond: C_NEVER, target: ST_IDLE};
      ST_PREP:    uw = '{accept: 1'b0, emit: 1'b0, op: OP_PREP,
                         cond: C_SPECIAL, target: ST_SPECIAL};
      ST_SCAN:    uw = '{accept: 1'b0, emit: 1'b0, op: OP_SCAN,
                         cond: C_SCAN_MORE, target: ST_SCAN};
      ST_PLACE:   uw = '{accept: 1'b0, emit: 1'b1, op: OP_PLACE,
                         cond: C_ALWAYS, target: ST_IDLE};
      ST_SPECIAL: uw = '{accept: 1'b0, emit: 1'b1, op: OP_SPECIAL,
                         cond: C_ALWAYS, target: ST_IDLE};
      default:    uw = '{accept: 1'b0, emit: 1'b0, op: OP_NONE,
                         cond: C_ALWAYS, target: ST_IDLE};
    endcase
  end

  // Hold on a missing item or a full result slot
  assign hold = (uw.accept && !in_valid) || (uw.emit && stat.out_busy);

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_SPECIAL:   jump = stat.special;
      C_SCAN_MORE: jump = stat.scan_more;
      default:     jump = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_ready  = uw.accept;
  assign ctrl.op   = uw.op;
  assign ctrl.fire = !hold;

endmodule

// ===== rtl/rra_datapath.sv =====
// Datapath of the ring record allocator: pointers, record memory, scan compare
// and the result register. Depends on rra_pkg.
module rra_datapath #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rra_pkg::CFG_W-1:0] cfg_buffer_bytes,
  input  logic                      in_command,
  input  logic [rra_pkg::PAY_W-1:0] in_payload_bytes,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_granted,
  output logic [rra_pkg::OFS_W-1:0] out_record_offset,
  output logic [rra_pkg::SEQ_W-1:0] out_record_seq,
  output logic [rra_pkg::SEQ_W-1:0] out_oldest_seq,
  output logic [rra_pkg::EVC_W-1:0] out_evicted_count,
  input  rra_pkg::dp_ctrl_t         ctrl,
  output rra_pkg::dp_stat_t         stat
);
  import rra_pkg::*;

  localparam int PTR_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int MEM_W = OFS_W + SEQ_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_RECORDS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RECORDS);
  localparam logic [EVC_W-1:0] EVC_MAX  = '1;

  // Item and control registers
  logic             cmd_r, cmd_nxt;
  logic             special_r, special_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [SZ_W-1:0]  size_r, size_nxt;
  logic [SZ_W-1:0]  wo_r, wo_nxt;
  logic [SZ_W-1:0]  cur_r, cur_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [EVC_W-1:0] evict_r, evict_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_granted_r, out_granted_nxt;
  logic [OFS_W-1:0] out_offset_r, out_offset_nxt;
  logic [SEQ_W-1:0] out_seq_r, out_seq_nxt;
  logic [SEQ_W-1:0] out_oldest_r, out_oldest_nxt;
  logic [EVC_W-1:0] out_evict_r, out_evict_nxt;

  // Record memory: start offset and sequence number per entry
  logic [MEM_W-1:0] mem [MAX_RECORDS];
  logic [MEM_W-1:0] rd_r;
  logic             mem_we;

  logic [TOT_W-1:0] tot_sum;
  logic [TOT_W-1:0] tot_calc;
  logic [SZ_W-1:0]  rd_start;
  logic [SEQ_W-1:0] rd_seq;
  logic [SZ_W-1:0]  total_ext;
  logic [SZ_W-1:0]  start_gap;
  logic [SZ_W-1:0]  room;
  logic             start_lt;
  logic             fits;
  logic             overlap;
  logic             list_empty;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [EVC_W-1:0] evict_inc;
  logic [SEQ_W-1:0] seq_inc;

  // Record size: header plus payload, rounded up to a word
  assign tot_sum  = TOT_W'(in_payload_bytes) + TOT_W'(HEADER_BYTES + 3);
  assign tot_calc = tot_sum & ~TOT_W'(3);

  assign rd_start   = SZ_W'(rd_r[MEM_W-1:SEQ_W]);
  assign rd_seq     = rd_r[SEQ_W-1:0];
  assign total_ext  = SZ_W'(total_r);
  assign list_empty = (count_r == '0);

  // Scan compares against the oldest record
  assign start_lt  = rd_start < cur_r;
  assign start_gap = rd_start - cur_r;
  assign room      = size_r - cur_r;
  assign fits      = (cur_r <= size_r) && (total_ext <= room);
  assign overlap   = !start_lt && (start_gap < total_ext);

  assign head_inc  = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc  = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign evict_inc = (evict_r == EVC_MAX) ? evict_r : evict_r + EVC_W'(1);
  assign seq_inc   = seq_r + SEQ_W'(1);

  assign stat.special   = special_r;
  assign stat.scan_more = !list_empty && ((start_lt && !fits) || overlap);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign mem_we = ctrl.fire && (ctrl.op == OP_PLACE);

  // Next state of the datapath
  always_comb begin
    cmd_nxt         = cmd_r;
    special_nxt     = special_r;
    total_nxt       = total_r;
    size_nxt        = size_r;
    wo_nxt          = wo_r;
    cur_nxt         = cur_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    seq_nxt         = seq_r;
    evict_nxt       = evict_r;
    out_granted_nxt = out_granted_r;
    out_offset_nxt  = out_offset_r;
    out_seq_nxt     = out_seq_r;
    out_oldest_nxt  = out_oldest_r;
    out_evict_nxt   = out_evict_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          cmd_nxt     = in_command;
          total_nxt   = tot_calc;
          special_nxt = in_command || (tot_calc > TOT_W'(OVERSIZE_LIMIT));
          evict_nxt   = '0;
        end
        OP_PREP: begin
          cur_nxt = wo_r;
          // Drop the oldest record when the list is full, except for a clear or refusal
          if (!special_r && count_r == CNT_FULL) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CNT_W'(1);
            evict_nxt = evict_inc;
          end
        end
        OP_SCAN: begin
          if (list_empty) begin
            cur_nxt = '0;
          end else if (start_lt) begin
            // Wrap to the buffer start when the tail does not fit
            if (!fits) begin
              cur_nxt = '0;
            end
          end else if (overlap) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CNT_W'(1);
            evict_nxt = evict_inc;
          end
        end
        OP_PLACE: begin
          seq_nxt         = seq_inc;
          tail_nxt        = tail_inc;
          count_nxt       = count_r + CNT_W'(1);
          wo_nxt          = cur_r + total_ext;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b1;
          out_offset_nxt  = cur_r[OFS_W-1:0];
          out_seq_nxt     = seq_inc;
          out_oldest_nxt  = list_empty ? seq_inc : rd_seq;
          out_evict_nxt   = evict_r;
        end
        OP_SPECIAL: begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
          out_offset_nxt  = '0;
          out_seq_nxt     = '0;
          out_evict_nxt   = '0;
          if (cmd_r) begin
            head_nxt       = '0;
            tail_nxt       = '0;
            count_nxt      = '0;
            wo_nxt         = '0;
            out_oldest_nxt = seq_r;
          end else begin
            out_oldest_nxt = list_empty ? seq_r : rd_seq;
          end
        end
        default: begin
        end
      endcase
    end

    // Resize and empty the buffer on a register write
    if (cfg_wr_en) begin
      if (cfg_buffer_bytes < SZ_W'(MIN_BUFFER_BYTES)) begin
        size_nxt = SZ_W'(MIN_BUFFER_BYTES);
      end else if (cfg_buffer_bytes > SZ_W'(MAX_BUFFER_BYTES)) begin
        size_nxt = SZ_W'(MAX_BUFFER_BYTES);
      end else begin
        size_nxt = cfg_buffer_bytes;
      end
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      wo_nxt    = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SZ_W'(MAX_BUFFER_BYTES);
      wo_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      wo_r        <= wo_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    special_r     <= special_nxt;
    total_r       <= total_nxt;
    cur_r         <= cur_nxt;
    evict_r       <= evict_nxt;
    out_granted_r <= out_granted_nxt;
    out_offset_r  <= out_offset_nxt;
    out_seq_r     <= out_seq_nxt;
    out_oldest_r  <= out_oldest_nxt;
    out_evict_r   <= out_evict_nxt;
  end

  // Record memory: write at the tail, read ahead at the next head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= {cur_r[OFS_W-1:0], seq_inc};
    end
    rd_r <= mem[head_nxt];
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_record_offset = out_offset_r;
  assign out_record_seq    = out_seq_r;
  assign out_oldest_seq    = out_oldest_r;
  assign out_evicted_count = out_evict_r;

endmodule

// ===== rtl/ring_record_allocator.sv =====
// Top level of the ring record allocator: sequencer plus datapath.
// Depends on rra_pkg, rra_sequencer and rra_datapath.
//
//   Channel  Direction  Handshake             Fields
//   cfg      in         cfg_wr_en             cfg_buffer_bytes
//   in       in         in_valid / in_ready   in_command, in_payload_bytes
//   out      out        out_valid / out_ready out_granted, out_record_offset,
//                                             out_record_seq, out_oldest_seq,
//                                             out_evicted_count
//
// An allocation runs one prepare step, one scan step per record evicted by the
// scan, one more when the write position wraps to offset 0 (at most once), a
// last scan step, then the place step, which registers the result. A full list
// drops its oldest record in the prepare step. Clear and refused requests run
// the prepare step, then the special step. No new item is taken before the
// result is registered. Reset (rst_n low, synchronous) empties the list and sets
// a 64 KiB buffer. A full result register stalls the final step until out_ready.
module ring_record_allocator #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rra_pkg::CFG_W-1:0] cfg_buffer_bytes,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [rra_pkg::PAY_W-1:0] in_payload_bytes,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_granted,
  output logic [rra_pkg::OFS_W-1:0] out_record_offset,
  output logic [rra_pkg::SEQ_W-1:0] out_record_seq,
  output logic [rra_pkg::SEQ_W-1:0] out_oldest_seq,
  output logic [rra_pkg::EVC_W-1:0] out_evicted_count
);
  import rra_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Step through the control program
  rra_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Hold pointers, records and the result
  rra_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_buffer_bytes  (cfg_buffer_bytes),
    .in_command        (in_command),
    .in_payload_bytes  (in_payload_bytes),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_granted       (out_granted),
    .out_record_offset (out_record_offset),
    .out_record_seq    (out_record_seq),
    .out_oldest_seq    (out_oldest_seq),
    .out_evicted_count (out_evicted_count),
    .ctrl              (ctrl),
    .stat              (stat)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ring_record_allocator: queued stimulus, handshake
// driver and result checker against an in-bench allocation predictor.
// Depends on rra_pkg and the ring_record_allocator RTL.
module testbench;
  import rra_pkg::*;

  localparam int          RECORD_SLOTS = 1024;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic        CMD_ALLOC    = 1'b0;
  localparam logic        CMD_CLEAR    = 1'b1;
  localparam int unsigned EVICT_SAT    = 2047;

  typedef struct packed {
    logic             cmd;
    logic [PAY_W-1:0] pay;
  } alloc_req_t;

  typedef struct packed {
    logic             granted;
    logic [OFS_W-1:0] offset;
    logic [SEQ_W-1:0] rec_seq;
    logic [SEQ_W-1:0] oldest;
    logic [EVC_W-1:0] evicted;
  } alloc_result_t;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             cfg_wr_en        = 1'b0;
  logic [CFG_W-1:0] cfg_buffer_bytes = '0;
  logic             in_valid         = 1'b0;
  logic             in_ready;
  logic             in_command       = CMD_ALLOC;
  logic [PAY_W-1:0] in_payload_bytes = '0;
  logic             out_valid;
  logic             out_ready        = 1'b0;
  logic             out_granted;
  logic [OFS_W-1:0] out_record_offset;
  logic [SEQ_W-1:0] out_record_seq;
  logic [SEQ_W-1:0] out_oldest_seq;
  logic [EVC_W-1:0] out_evicted_count;

  // Pending requests and the allocation results they should produce
  alloc_req_t    pending_reqs[$];
  alloc_result_t expected_allocs[$];

  int send_idle_pct = 17;
  int recv_idle_pct = 60;
  int cycles        = 0;
  int mismatches    = 0;
  int n_results     = 0;
  int n_granted     = 0;
  int n_refused     = 0;
  int n_clears      = 0;
  int n_evicted     = 0;
  int max_evicted   = 0;

  // Predictor state: ring geometry, record list and sequence counter
  logic [CFG_W-1:0] buf_cfg;
  int unsigned      wr_pos;
  int unsigned      rec_start[RECORD_SLOTS];
  logic [SEQ_W-1:0] rec_seq[RECORD_SLOTS];
  int unsigned      list_head;
  int unsigned      list_tail;
  int unsigned      list_count;
  logic [SEQ_W-1:0] seq_ctr;

  ring_record_allocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_buffer_bytes  (cfg_buffer_bytes),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_payload_bytes  (in_payload_bytes),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_record_offset (out_record_offset),
    .out_record_seq    (out_record_seq),
    .out_oldest_seq    (out_oldest_seq),
    .out_evicted_count (out_evicted_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Empty the record list and rewind the write position
  function automatic void clear_list();
    list_head  = 0;
    list_tail  = 0;
    list_count = 0;
    wr_pos     = 0;
  endfunction

  // Drop the oldest live record
  function automatic void drop_oldest_record();
    if (list_count != 0) begin
      list_head  = (list_head + 1) % RECORD_SLOTS;
      list_count = list_count - 1;
    end
  endfunction

  // Compute the result of one request and advance the predictor state
  function automatic alloc_result_t alloc_predict(logic cmd, logic [PAY_W-1:0] pay);
    alloc_result_t r;
    int unsigned   total;
    int unsigned   span;
    int unsigned   cur;
    int unsigned   start;
    int unsigned   evicted;
    r       = '0;
    evicted = 0;
    if (cmd == CMD_CLEAR) begin
      clear_list();
      r.oldest = seq_ctr;
      return r;
    end
    total = (HEADER_BYTES + int'(pay) + 3) & 32'hFFFF_FFFC;
    if (total > OVERSIZE_LIMIT) begin
      n_refused++;
      r.oldest = (list_count != 0) ? rec_seq[list_head] : seq_ctr;
      return r;
    end
    span = 32'(buf_cfg);
    if (span < MIN_BUFFER_BYTES) span = MIN_BUFFER_BYTES;
    if (span > MAX_BUFFER_BYTES) span = MAX_BUFFER_BYTES;
    // Full list: evict the oldest before placing
    if (list_count >= RECORD_SLOTS) begin
      drop_oldest_record();
      evicted++;
    end
    cur = wr_pos;
    if (list_count == 0) begin
      cur = 0;
    end else begin
      // Scan forward, wrapping to zero and evicting records in the way
      while (1) begin
        start = rec_start[list_head];
        if (start < cur) begin
          if (cur <= span && total <= span - cur) break;
          cur = 0;
        end
        while (start >= cur && start - cur < total) begin
          drop_oldest_record();
          evicted++;
          if (list_count == 0) begin
            cur = 0;
            break;
          end
          start = rec_start[list_head];
        end
        if (list_count == 0 || start > cur) break;
      end
    end
    seq_ctr              = seq_ctr + 1;
    rec_start[list_tail] = cur;
    rec_seq[list_tail]   = seq_ctr;
    list_tail            = (list_tail + 1) % RECORD_SLOTS;
    list_count           = list_count + 1;
    wr_pos               = cur + total;
    r.granted = 1'b1;
    r.offset  = cur[OFS_W-1:0];
    r.rec_seq = seq_ctr;
    r.oldest  = rec_seq[list_head];
    r.evicted = (evicted > EVICT_SAT) ? EVICT_SAT[EVC_W-1:0] : evicted[EVC_W-1:0];
    return r;
  endfunction

  // Drive request items; hold the payload while the block stalls
  always @(posedge clk) begin : drive_items
    alloc_req_t nxt;
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_command       <= CMD_ALLOC;
      in_payload_bytes <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_allocs.push_back(alloc_predict(in_command, in_payload_bytes));
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (pending_reqs.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_valid         <= 1'b1;
        in_command       <= nxt.cmd;
        in_payload_bytes <= nxt.pay;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accept results and compare them with the oldest expectation
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) > recv_idle_pct);
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_allocs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result: granted=%0d offset=%0d seq=%0d", $realtime,
                     out_granted, out_record_offset, out_record_seq);
        end else begin
          want = expected_allocs.pop_front();
          if (want.granted) begin
            n_granted++;
            n_evicted += int'(want.evicted);
            if (int'(want.evicted) > max_evicted) max_evicted = int'(want.evicted);
          end
          if (out_granted !== want.granted || out_record_offset !== want.offset ||
              out_record_seq !== want.rec_seq || out_oldest_seq !== want.oldest ||
              out_evicted_count !== want.evicted) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] mismatch: exp granted=%0d offset=%0d seq=%0d oldest=%0d evict=%0d",
                       $realtime, want.granted, want.offset, want.rec_seq, want.oldest,
                       want.evicted);
              $display("              got granted=%0d offset=%0d seq=%0d oldest=%0d evict=%0d",
                       out_granted, out_record_offset, out_record_seq, out_oldest_seq,
                       out_evicted_count);
            end
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               expected_allocs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic alloc_req_t make_req(logic cmd, int pay);
    alloc_req_t r;
    r.cmd = cmd;
    r.pay = pay[PAY_W-1:0];
    return r;
  endfunction

  // Queue random requests: mostly fitting allocations, some oversize, few clears
  task automatic queue_random(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        pending_reqs.push_back(make_req(CMD_CLEAR, $urandom_range(0, 4095)));
        n_clears++;
      end else if (pick < 13) begin
        pending_reqs.push_back(make_req(CMD_ALLOC, $urandom_range(1985, 4095)));
      end else if (pick < 33) begin
        pending_reqs.push_back(make_req(CMD_ALLOC, $urandom_range(1024, 1984)));
      end else begin
        pending_reqs.push_back(make_req(CMD_ALLOC, $urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every queued item was sent and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_allocs.size() != 0);
  endtask

  // Write the buffer size once the block is idle; the write empties the list
  task automatic write_buffer_size(logic [CFG_W-1:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_wr_en        <= 1'b1;
    cfg_buffer_bytes <= v;
    buf_cfg = v;
    clear_list();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    buf_cfg = CFG_W'(MAX_BUFFER_BYTES);
    seq_ctr = '0;
    clear_list();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: size limits, bit patterns, clear and allocation after clear
    pending_reqs.push_back(make_req(CMD_ALLOC, 0));
    pending_reqs.push_back(make_req(CMD_ALLOC, 4095));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1984));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1985));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1981));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1));
    pending_reqs.push_back(make_req(CMD_ALLOC, 2));
    pending_reqs.push_back(make_req(CMD_ALLOC, 3));
    pending_reqs.push_back(make_req(CMD_ALLOC, 'h555));
    pending_reqs.push_back(make_req(CMD_ALLOC, 'hAAA));
    pending_reqs.push_back(make_req(CMD_CLEAR, 'hFFF));
    pending_reqs.push_back(make_req(CMD_ALLOC, 5));
    pending_reqs.push_back(make_req(CMD_CLEAR, 0));
    n_clears += 2;

    // Directed: smallest buffer, force wrap and eviction of the oldest
    write_buffer_size(CFG_W'(MIN_BUFFER_BYTES));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1984));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1984));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1984));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1000));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1000));
    pending_reqs.push_back(make_req(CMD_ALLOC, 1984));
    pending_reqs.push_back(make_req(CMD_ALLOC, 0));

    // Random, below-range size clamps to the minimum buffer
    write_buffer_size('0);
    queue_random(130);

    // Random, random size; pause the sender halfway until all results return
    write_buffer_size(CFG_W'($urandom_range(0, 131071)));
    send_idle_pct = 60;
    recv_idle_pct = 17;
    queue_random(65);
    wait_drained();
    queue_random(65);

    // Random, above-range size clamps to the maximum buffer, no idling
    write_buffer_size('1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(130);

    // Mix at the exact maximum buffer size
    write_buffer_size(CFG_W'(MAX_BUFFER_BYTES));
    queue_random(20);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d results: %0d granted, %0d refused, %0d clears queued",
             n_results, n_granted, n_refused, n_clears);
    $display("Evicted %0d records in total, at most %0d in one allocation",
             n_evicted, max_evicted);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
